[hdl/scrf_pkg.sv]
// shared types and constants for the sensor change report filter
`default_nettype none

package scrf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REPORT_W   = 5;

    // operation codes
    localparam logic [1:0] OP_EVAL   = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_FORCE  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_DELTA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_DELTA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_DELTA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_DELTA      = 3'd4;

    // report mask bits
    localparam int RPT_TEMP     = 0;
    localparam int RPT_HUMIDITY = 1;
    localparam int RPT_PRESSURE = 2;
    localparam int RPT_BATTERY  = 3;
    localparam int RPT_TAG      = 4;
    localparam logic [REPORT_W-1:0] ALL_REPORTS = 5'b11111;

    // valid mask bits
    localparam int VLD_CLIMATE  = 0;
    localparam int VLD_PRESSURE = 1;
    localparam int VLD_BATTERY  = 2;
    localparam int VLD_GAS      = 3;

    typedef struct packed {
        logic [1:0]          operation;
        logic [31:0]         timestamp;
        logic [3:0]          valid_mask;
        logic signed [15:0]  temperature;
        logic [15:0]         humidity;
        logic signed [31:0]  pressure;
        logic [7:0]          battery;
        logic [31:0]         gas;
        logic [39:0]         status_word;
        logic [63:0]         event_counts;
        logic [REPORT_W-1:0] commit_mask;
    } t_in_item;

    typedef struct packed {
        logic [REPORT_W-1:0] report_mask;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_beat;

    typedef struct packed {
        logic [31:0] max_interval;
        logic [15:0] temp_delta;
        logic [15:0] humidity_delta;
        logic [31:0] pressure_delta;
        logic [31:0] gas_delta;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [31:0]        last_time;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic signed [31:0] pressure;
        logic [7:0]         battery;
        logic [39:0]        status_word;
        logic [63:0]        event_counts;
        logic [31:0]        gas;
    } t_base;

endpackage

`default_nettype wire

[hdl/scrf_in_if.sv]
// sample input channel
`default_nettype none

interface scrf_in_if;
    logic              valid;
    logic              ready;
    scrf_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/scrf_out_if.sv]
// report result channel
`default_nettype none

interface scrf_out_if;
    logic               valid;
    logic               ready;
    scrf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/scrf_cfg_if.sv]
// configuration write channel
`default_nettype none

interface scrf_cfg_if;
    logic               valid;
    logic               ready;
    scrf_pkg::t_cfg_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/scrf_eval.sv]
// deadband and heartbeat compare of one sample against the held baselines
`default_nettype none

module scrf_eval (
    input  wire scrf_pkg::t_in_item             i_item,
    input  wire scrf_pkg::t_base                i_base,
    input  wire scrf_pkg::t_cfg                 i_cfg,
    output logic [scrf_pkg::REPORT_W-1:0]       o_mask
);

    logic [31:0]        elapsed;
    logic signed [16:0] temp_diff;
    logic signed [16:0] hum_diff;
    logic signed [32:0] pres_diff;
    logic signed [32:0] gas_diff;
    logic [16:0]        temp_abs;
    logic [16:0]        hum_abs;
    logic [32:0]        pres_abs;
    logic [32:0]        gas_abs;
    logic [scrf_pkg::REPORT_W-1:0] change;

    assign elapsed = i_item.timestamp - i_base.last_time;

    always_comb begin
        temp_diff = 17'(i_item.temperature) - 17'(i_base.temperature);
        hum_diff  = $signed({1'b0, i_item.humidity}) - $signed({1'b0, i_base.humidity});
        pres_diff = 33'(i_item.pressure) - 33'(i_base.pressure);
        gas_diff  = $signed({1'b0, i_item.gas}) - $signed({1'b0, i_base.gas});

        temp_abs = temp_diff[16] ? 17'(-temp_diff) : 17'(temp_diff);
        hum_abs  = hum_diff[16]  ? 17'(-hum_diff)  : 17'(hum_diff);
        pres_abs = pres_diff[32] ? 33'(-pres_diff) : 33'(pres_diff);
        gas_abs  = gas_diff[32]  ? 33'(-gas_diff)  : 33'(gas_diff);

        change = '0;
        if (i_item.valid_mask[scrf_pkg::VLD_CLIMATE]) begin
            change[scrf_pkg::RPT_TEMP]     = temp_abs >= {1'b0, i_cfg.temp_delta};
            change[scrf_pkg::RPT_HUMIDITY] = hum_abs >= {1'b0, i_cfg.humidity_delta};
        end
        change[scrf_pkg::RPT_PRESSURE] = i_item.valid_mask[scrf_pkg::VLD_PRESSURE]
                                         && (pres_abs >= {1'b0, i_cfg.pressure_delta});
        change[scrf_pkg::RPT_BATTERY]  = i_item.valid_mask[scrf_pkg::VLD_BATTERY]
                                         && (i_item.battery != i_base.battery);
        // gas check is off while its threshold is zero
        change[scrf_pkg::RPT_TAG] = (i_item.valid_mask[scrf_pkg::VLD_GAS]
                                     && (i_cfg.gas_delta != '0)
                                     && (gas_abs >= {1'b0, i_cfg.gas_delta}))
                                    || (i_item.status_word != i_base.status_word)
                                    || (i_item.event_counts != i_base.event_counts);

        if (!i_base.valid || (elapsed >= i_cfg.max_interval)) begin
            o_mask = scrf_pkg::ALL_REPORTS;
        end else begin
            o_mask = change;
        end
    end

endmodule

`default_nettype wire

[hdl/sensor_change_report_filter.sv]
// top level: sample register, baseline state and report register
// an accepted beat is held in the sample register before its report is registered
// throughput: one beat per cycle, set by the single compare stage between the
// sample register and the report register; stalls only when the report waits
// reset (synchronous, active low) clears the thresholds, the interval,
// all baselines and the baseline valid flag; no clearing pass is needed
`default_nettype none

module sensor_change_report_filter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    scrf_in_if.sink     i_in,
    scrf_out_if.source  o_out,
    scrf_cfg_if.sink    i_cfg
);

    scrf_pkg::t_cfg     r_cfg;
    scrf_pkg::t_cfg     n_cfg;
    scrf_pkg::t_base    r_base;
    scrf_pkg::t_base    n_base;
    scrf_pkg::t_in_item r_item;
    logic               r_item_valid;
    logic [scrf_pkg::REPORT_W-1:0] r_mask;
    logic [scrf_pkg::REPORT_W-1:0] n_mask;
    logic               r_out_valid;
    logic [scrf_pkg::REPORT_W-1:0] eval_mask;
    logic               advance;

    // the held item moves on whenever the report slot is free or being taken
    assign advance     = r_item_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_item_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_out_valid;
    assign o_out.data.report_mask = r_mask;

    scrf_eval u_eval (
        .i_item (r_item),
        .i_base (r_base),
        .i_cfg  (r_cfg),
        .o_mask (eval_mask)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.data.index)
                scrf_pkg::REG_MAX_INTERVAL:   n_cfg.max_interval   = i_cfg.data.value;
                scrf_pkg::REG_TEMP_DELTA:     n_cfg.temp_delta     = i_cfg.data.value[15:0];
                scrf_pkg::REG_HUMIDITY_DELTA: n_cfg.humidity_delta = i_cfg.data.value[15:0];
                scrf_pkg::REG_PRESSURE_DELTA: n_cfg.pressure_delta = i_cfg.data.value;
                scrf_pkg::REG_GAS_DELTA:      n_cfg.gas_delta      = i_cfg.data.value;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_base = r_base;
        n_mask = '0;
        case (r_item.operation)
            scrf_pkg::OP_EVAL: begin
                n_mask = eval_mask;
            end
            scrf_pkg::OP_COMMIT: begin
                if (r_item.commit_mask != '0) begin
                    if (r_item.commit_mask[scrf_pkg::RPT_TEMP])
                        n_base.temperature = r_item.temperature;
                    if (r_item.commit_mask[scrf_pkg::RPT_HUMIDITY])
                        n_base.humidity = r_item.humidity;
                    if (r_item.commit_mask[scrf_pkg::RPT_PRESSURE])
                        n_base.pressure = r_item.pressure;
                    if (r_item.commit_mask[scrf_pkg::RPT_BATTERY])
                        n_base.battery = r_item.battery;
                    if (r_item.commit_mask[scrf_pkg::RPT_TAG]) begin
                        n_base.status_word  = r_item.status_word;
                        n_base.event_counts = r_item.event_counts;
                        if (r_item.valid_mask[scrf_pkg::VLD_GAS])
                            n_base.gas = r_item.gas;
                    end
                    n_base.last_time = r_item.timestamp;
                    n_base.valid     = 1'b1;
                end
            end
            scrf_pkg::OP_FORCE: begin
                n_base.valid = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_base       <= '0;
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (advance) begin
                r_base <= n_base;
            end
            if (i_in.valid && i_in.ready) begin
                r_item_valid <= 1'b1;
            end else if (advance) begin
                r_item_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
        if (advance) begin
            r_mask <= n_mask;
        end
    end

`ifndef SYNTHESIS
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.operation == scrf_pkg::OP_COMMIT) && (r_item.commit_mask != '0)
        |=> r_base.valid)
        else $error("commit did not mark the baseline valid");

    a_non_eval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.operation != scrf_pkg::OP_EVAL)
        |=> (o_out.valid && (o_out.data.report_mask == '0)))
        else $error("commit or force beat gave a nonzero report");

    a_no_base_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_item.operation == scrf_pkg::OP_EVAL) && !r_base.valid
        |=> (o_out.data.report_mask == scrf_pkg::ALL_REPORTS))
        else $error("evaluate without baseline did not report all");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty report slot");
`endif

endmodule

`default_nettype wire
